### rtl/mh2_pkg.sv
// mh2_pkg: constants, the multiplier request type and helpers shared by the MurmurHash2 stream block.
// No dependencies.
`timescale 1ns / 1ps

package mh2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;
  localparam logic [31:0] SEED_RESET  = 32'd5381;

  // byte count that marks a full word
  localparam logic [2:0]  CNT_FULL    = 3'd4;
  localparam logic [2:0]  CNT_NONE    = 3'd0;
  localparam logic [2:0]  CNT_ONE     = 3'd1;
  localparam logic [2:0]  CNT_TWO     = 3'd2;

  // operand to the shared multiplier
  typedef struct packed {
    logic        en;
    logic [31:0] a;
  } mul_req_t;

  // keep the low count bytes of a tail word (count 1..3)
  function automatic logic [31:0] tail_bytes(input logic [31:0] w, input logic [2:0] n);
    logic [31:0] m;
    begin
      case (n)
        CNT_ONE: m = 32'h0000_00ff;
        CNT_TWO: m = 32'h0000_ffff;
        default: m = 32'h00ff_ffff;
      endcase
      tail_bytes = w & m;
    end
  endfunction

endpackage

### rtl/mh2_mul.sv
// mh2_mul: shared multiply by the MurmurHash2 constant, result registered.
// Depends on mh2_pkg.
`timescale 1ns / 1ps

module mh2_mul
  import mh2_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [31:0] p
);

  // low 32 bits of operand * MIX_MUL; holds when not enabled
  always_ff @(posedge clk) begin
    if (req.en) begin
      p <= req.a * MIX_MUL;
    end
  end

endmodule

### rtl/murmurhash2_stream.sv
// murmurhash2_stream: streaming 32-bit MurmurHash2, one shared constant multiplier
// under a small sequencer. Depends on mh2_pkg and mh2_mul.
`timescale 1ns / 1ps
//
//  channel   signals                                         dir   beat when
//  -------   ----------------------------------------------  ----  ---------------------
//  input     in_valid, in_stall, data_word, byte_count,      in    in_valid & !in_stall
//            first, last, total_len
//  output    out_valid, out_stall, hash                      out   out_valid & !out_stall
//  config    cfg_we, cfg_wdata (seed)                        in    cfg_we
//
// Steps per input beat, in order, all on the one multiplier that every product shares:
//   full word (count >= 4): accept, k*M, mix*M, h*M, combine
//   tail (count 1..3): accept, h*M, combine; empty word: accept only
//   a last beat adds finalize multiply and output load, plus any wait on out_stall.
// Synchronous active-high reset: seed = 5381, running hash = 0, sequencer idle.
// in_stall is high whenever the sequencer is busy. While out_valid and out_stall are
// both high the hash register holds and the finished value waits in the finalize state.

module murmurhash2_stream
  import mh2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        first,
  input  logic        last,
  input  logic [30:0] total_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash
);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KMUL  = 3'd1;  // k = word * M
  localparam logic [2:0] S_KMIX  = 3'd2;  // k = (k ^ k>>24) * M
  localparam logic [2:0] S_HMUL  = 3'd3;  // h * M
  localparam logic [2:0] S_HCOMB = 3'd4;  // h = h*M ^ k
  localparam logic [2:0] S_FIN   = 3'd5;  // (h ^ h>>13) * M
  localparam logic [2:0] S_FOUT  = 3'd6;  // hash = p ^ p>>15

  logic [2:0]  state;
  logic [31:0] seed;
  logic [31:0] h;       // running hash
  logic [31:0] k;       // mixed word, zero for a tail
  logic        full_q;
  logic        last_q;
  logic [31:0] p;
  mul_req_t    mreq;

  logic        accept;
  logic        out_load;
  logic        in_full;
  logic [31:0] h_init;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // counts 5..7 behave as a full word
  assign in_full  = byte_count[2];
  assign h_init   = first ? (seed ^ {1'b0, total_len}) : h;
  assign out_load = (state == S_FOUT) && (!out_valid || !out_stall);

  // operand select for the shared multiplier
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = h;
    case (state)
      S_KMUL: begin
        mreq.en = 1'b1;
        mreq.a  = k;
      end
      S_KMIX: begin
        mreq.en = 1'b1;
        mreq.a  = p ^ (p >> MIX_SHIFT);
      end
      S_HMUL: begin
        mreq.en = 1'b1;
        mreq.a  = h;
      end
      S_FIN: begin
        mreq.en = 1'b1;
        mreq.a  = h ^ (h >> FIN_SHIFT_A);
      end
      default: begin
        mreq.en = 1'b0;
        mreq.a  = h;
      end
    endcase
  end

  mh2_mul u_mul (
    .clk (clk),
    .req (mreq),
    .p   (p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  // sequencer and running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      h      <= '0;
      full_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            full_q <= in_full;
            last_q <= last;
            if (in_full) begin
              h     <= h_init;
              state <= S_KMUL;
            end else if (byte_count != CNT_NONE) begin
              h     <= h_init ^ tail_bytes(data_word, byte_count);
              state <= S_HMUL;
            end else begin
              h     <= h_init;
              state <= last ? S_FIN : S_IDLE;
            end
          end
        end
        S_KMUL:  state <= S_KMIX;
        S_KMIX:  state <= S_HMUL;
        S_HMUL:  state <= S_HCOMB;
        S_HCOMB: begin
          h     <= p ^ k;
          state <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN:   state <= S_FOUT;
        S_FOUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // word / mix operand; a tail combines with zero
  always_ff @(posedge clk) begin
    if (accept) begin
      k <= in_full ? data_word : '0;
    end else if (state == S_HMUL && full_q) begin
      k <= p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash <= p ^ (p >> FIN_SHIFT_B);
    end
  end

  // checks
  a_comb_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_HCOMB) |-> ($past(state) == S_HMUL))
    else $error("combine step without a preceding h multiply");

  a_kmul_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_KMUL || state == S_KMIX) |-> full_q)
    else $error("word mix entered for a tail beat");

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN || state == S_FOUT) |-> last_q)
    else $error("finalize entered for a beat that is not last");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FOUT))
    else $error("hash presented without finalize");

endmodule
